[hw/rtl/brl_pkg.sv]
// Shared types, constants and the control program of the line rasterizer.
package brl_pkg;

  localparam int unsigned CoordW = 6;
  localparam int unsigned ColorW = 8;
  localparam int unsigned ErrW   = 8;

  localparam int unsigned FRAME_WIDTH  = 64;
  localparam int unsigned FRAME_HEIGHT = 50;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  localparam int unsigned PcW = 2;
  typedef logic [PcW-1:0] brl_pc_t;

  // Program step addresses
  localparam brl_pc_t StepIdle  = 2'd0;
  localparam brl_pc_t StepOrder = 2'd1;
  localparam brl_pc_t StepDraw  = 2'd2;
  localparam brl_pc_t StepDone  = 2'd3;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } brl_wait_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_ZERO_SPAN,
    JMP_MORE
  } brl_jmp_e;

  typedef struct packed {
    brl_wait_e wait_on;
    logic      do_load;
    logic      do_order;
    logic      do_emit;
    brl_jmp_e  jmp;
    brl_pc_t   target;
  } brl_uword_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic zero_span;
    logic more;
  } brl_stat_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic order;
    logic emit;
  } brl_ctrl_t;

  function automatic brl_uword_t brl_rom(brl_pc_t pc);
    brl_uword_t uw;
    uw = '{wait_on: WAIT_NONE, do_load: 1'b0, do_order: 1'b0, do_emit: 1'b0,
           jmp: JMP_ALWAYS, target: StepIdle};
    unique case (pc)
      StepIdle: begin
        uw.wait_on = WAIT_IN;
        uw.do_load = 1'b1;
        uw.jmp     = JMP_NEXT;
      end
      StepOrder: begin
        uw.do_order = 1'b1;
        uw.jmp      = JMP_ZERO_SPAN;
        uw.target   = StepIdle;
      end
      StepDraw: begin
        uw.wait_on = WAIT_OUT;
        uw.do_emit = 1'b1;
        uw.jmp     = JMP_MORE;
        uw.target  = StepDraw;
      end
      StepDone: begin
        uw.jmp    = JMP_ALWAYS;
        uw.target = StepIdle;
      end
      default: begin
        uw.jmp    = JMP_ALWAYS;
        uw.target = StepIdle;
      end
    endcase
    return uw;
  endfunction

endpackage

[hw/rtl/bresenham_line_rasterizer_core.sv]
// Top level of the line rasterizer: command capture, stepping datapath, output register.
//
//  channel | dir | tdata (low bit first)                     | tuser    | tlast
//  s_axis  | in  | start_x, start_y, end_x, end_y, color      | -        | -
//  m_axis  | out | pixel_x, pixel_y, pixel_value (8 bits)    | on_frame | last pixel
//
// A line runs through the idle, order and draw steps of the microcode program and ends
// with the done step; the draw step emits one pixel per cycle while m_axis is not stalled.
// A zero-length span returns from the order step to idle and emits no word.
// Reset clears the step counter and the output valid flag.
// A stalled m_axis holds the draw step; the output register lets the last
// pixel wait while the next command is taken.
module bresenham_line_rasterizer_core import brl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // start_x, start_y, end_x, end_y, color
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // pixel_x, pixel_y, pixel_value, 4'b0
  output logic                m_axis_tuser,   // on_frame
  output logic                m_axis_tlast
);

  typedef logic [CoordW-1:0] coord_t;

  brl_stat_t stat;
  brl_ctrl_t ctrl;

  coord_t in_sx, in_sy, in_ex, in_ey;
  logic [ColorW-1:0] in_color;
  coord_t dx, dy;
  logic   steep;

  coord_t a_maj_q, a_min_q, b_maj_q, b_min_q;
  logic   swap_q;
  logic [ColorW-1:0] color_q;

  coord_t maj_q, min_q, end_q, dmaj_q, dmin_q;
  logic   down_q;
  logic signed [ErrW-1:0] err_q;

  coord_t maj0, min0, maj1, min1;
  logic   order_gt;

  coord_t px, py;
  logic   on_frame;
  logic   more;
  logic signed [ErrW:0] err_sub, err_add;

  logic                out_valid_q;
  coord_t              out_x_q, out_y_q;
  logic [ColorW-1:0]   out_val_q;
  logic                out_on_q, out_last_q;

  assign in_sx    = s_axis_tdata[5:0];
  assign in_sy    = s_axis_tdata[11:6];
  assign in_ex    = s_axis_tdata[17:12];
  assign in_ey    = s_axis_tdata[23:18];
  assign in_color = s_axis_tdata[31:24];

  assign dx    = (in_sx > in_ex) ? in_sx - in_ex : in_ex - in_sx;
  assign dy    = (in_sy > in_ey) ? in_sy - in_ey : in_ey - in_sy;
  assign steep = dy > dx;

  // order endpoints along the major axis
  assign order_gt = a_maj_q > b_maj_q;
  assign maj0 = order_gt ? b_maj_q : a_maj_q;
  assign min0 = order_gt ? b_min_q : a_min_q;
  assign maj1 = order_gt ? a_maj_q : b_maj_q;
  assign min1 = order_gt ? a_min_q : b_min_q;

  assign px       = swap_q ? min_q : maj_q;
  assign py       = swap_q ? maj_q : min_q;
  assign on_frame = ({1'b0, px} < (CoordW+1)'(FRAME_WIDTH)) &&
                    ({1'b0, py} < (CoordW+1)'(FRAME_HEIGHT));
  assign more     = (maj_q + coord_t'(1)) != end_q;

  assign err_sub = {err_q[ErrW-1], err_q} - $signed({2'b00, dmin_q, 1'b0});
  assign err_add = err_sub + $signed({2'b00, dmaj_q, 1'b0});

  assign stat.in_valid  = s_axis_tvalid;
  assign stat.out_free  = !out_valid_q || m_axis_tready;
  assign stat.zero_span = (a_maj_q == b_maj_q);
  assign stat.more      = more;

  brl_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign s_axis_tready = ctrl.in_ready;

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      swap_q  <= steep;
      a_maj_q <= steep ? in_sy : in_sx;
      a_min_q <= steep ? in_sx : in_sy;
      b_maj_q <= steep ? in_ey : in_ex;
      b_min_q <= steep ? in_ex : in_ey;
      color_q <= in_color;
    end
    if (ctrl.order) begin
      maj_q  <= maj0;
      min_q  <= min0;
      end_q  <= maj1;
      dmaj_q <= maj1 - maj0;
      dmin_q <= (min0 > min1) ? min0 - min1 : min1 - min0;
      down_q <= !(min0 < min1);
      err_q  <= $signed({2'b00, maj1 - maj0});
    end else if (ctrl.emit) begin
      // advance the major axis; step the minor axis when the error goes negative
      maj_q <= maj_q + coord_t'(1);
      if (err_sub < 0) begin
        min_q <= down_q ? min_q - coord_t'(1) : min_q + coord_t'(1);
        err_q <= err_add[ErrW-1:0];
      end else begin
        err_q <= err_sub[ErrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_x_q    <= px;
      out_y_q    <= py;
      out_val_q  <= color_q;
      out_on_q   <= on_frame;
      out_last_q <= !more;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_val_q, out_y_q, out_x_q};
  assign m_axis_tuser  = out_on_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[hw/rtl/brl_seq.sv]
// Microcode sequencer: step counter, program table and conditional jumps.
module brl_seq import brl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  brl_stat_t stat_i,
  output brl_ctrl_t ctrl_o
);

  brl_pc_t    pc_q, pc_d;
  brl_uword_t uw;
  logic       go;
  logic       taken;

  always_comb begin
    uw = brl_rom(pc_q);
    case (uw.wait_on)
      WAIT_IN:  go = stat_i.in_valid;
      WAIT_OUT: go = stat_i.out_free;
      default:  go = 1'b1;
    endcase
    case (uw.jmp)
      JMP_ALWAYS:    taken = 1'b1;
      JMP_ZERO_SPAN: taken = stat_i.zero_span;
      JMP_MORE:      taken = stat_i.more;
      default:       taken = 1'b0;
    endcase
    ctrl_o.in_ready = (uw.wait_on == WAIT_IN);
    ctrl_o.load     = uw.do_load & go;
    ctrl_o.order    = uw.do_order & go;
    ctrl_o.emit     = uw.do_emit & go;
    // hold the step until its wait condition is met
    if (!go) begin
      pc_d = pc_q;
    end else if (taken) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + brl_pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

[hw/rtl/brl_checker.sv]
// Port-level checks of the line rasterizer and their binding to the top level.
module brl_checker import brl_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser,
  input logic                m_axis_tlast
);

  logic s_acc, m_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  // a command goes through setup before the next one is taken
  a_setup_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input taken again right after a command");

  // no command is taken while a line is still being drawn
  a_busy_mid_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_acc && !m_axis_tlast) |=> !s_axis_tready)
    else $error("input ready in the middle of a line");

  // on_frame follows the row against the frame height
  a_on_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser == ({1'b0, m_axis_tdata[11:6]} < (CoordW+1)'(FRAME_HEIGHT))))
    else $error("on_frame disagrees with pixel row");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output word changed while stalled");

endmodule

bind bresenham_line_rasterizer_core brl_checker u_brl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
